// ===== design/swss_pkg.sv =====
// Shared types, register indexes and limits of the shallow-water stencil block.
`timescale 1ns / 1ps

package swss_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_MASS    = 2'd0;
	localparam logic [1:0] REG_GRAVITY = 2'd1;
	localparam logic [1:0] REG_WIDTH   = 2'd2;
	localparam logic [1:0] REG_HEIGHT  = 2'd3;

	// Register reset values.
	localparam logic [15:0] MASS_RESET    = 16'd1311;
	localparam logic [15:0] GRAVITY_RESET = 16'd6423;
	localparam logic [8:0]  WIDTH_RESET   = 9'd125;
	localparam logic [12:0] HEIGHT_RESET  = 13'd450;

	// Geometry limits; coordinates inside the block are twelve bits wide.
	localparam logic [12:0] MIN_DIM  = 13'd3;
	localparam logic [12:0] MAX_ROWS = 13'd4096;
	localparam int          COORD_W  = 12;

	// One grid cell as it arrives and as it sits in the row store.
	typedef struct packed {
		logic signed [23:0] hp;
		logic signed [23:0] hc;
		logic signed [23:0] u;
		logic signed [23:0] v;
		logic        [22:0] d;
	} cell_t;

	// How a cell is handled.
	typedef struct packed {
		logic emit_up;
		logic on_edge;
		logic emit_last;
		logic frame_end;
	} flags_t;

	// A classified cell travelling from front to back.
	typedef struct packed {
		cell_t               data;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		flags_t              flags;
	} item_t;

	// Clamped geometry in use.
	typedef struct packed {
		logic [12:0] w;
		logic [12:0] h;
	} geom_t;

	// One result word.
	typedef struct packed {
		logic        [7:0]  x;
		logic        [11:0] y;
		logic signed [23:0] hn;
		logic signed [23:0] un;
		logic signed [23:0] vn;
		logic               run_last;
		logic               frame_end;
	} result_t;

	// Saturate a wide signed value to 24 bits.
	function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
		logic signed [23:0] r;
		if (v > 40'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -40'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

// ===== design/swss_fifo.sv =====
// Small register queue used between front and back and for results.
`timescale 1ns / 1ps

module swss_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Word storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== design/swss_front.sv =====
// Front end: raster position tracking and classification of incoming cells.
`timescale 1ns / 1ps

module swss_front
	import swss_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cell_t cell_in,
	input  geom_t geom,
	input  logic  q_full,
	output logic  q_push,
	output item_t q_item
);

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic               x_last;
	logic               y_last;

	assign x_last = (13'(col_q) + 13'd1 >= geom.w);
	assign y_last = (13'(row_q) + 13'd1 >= geom.h);
	assign q_push = push && !q_full;

	// Classify the cell at the current raster position.
	always_comb begin
		q_item.data            = cell_in;
		q_item.x               = col_q;
		q_item.y               = row_q;
		q_item.flags.emit_up   = (row_q != '0);
		q_item.flags.on_edge   = (col_q == '0) || x_last || (row_q == COORD_W'(1));
		q_item.flags.emit_last = y_last;
		q_item.flags.frame_end = x_last;
	end

	// Raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (x_last) begin
				col_q <= '0;
				row_q <= y_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ===== design/swss_back.sv =====
// Back end: row store, stencil arithmetic pipeline and result issue.
`timescale 1ns / 1ps

module swss_back
	import swss_pkg::*;
#(
	parameter int COL_W = 8,
	parameter int RES_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	input  logic [15:0] c0,
	input  logic [15:0] c1,
	output logic        res_push,
	output result_t     res_data,
	input  logic        res_pop
);

	localparam int AW = COL_W + 1;
	localparam int RW = $clog2(RES_DEPTH + 1);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	state_t          state_q;
	logic [RW-1:0]   reserved_q;
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	logic            issue;
	logic [1:0]      n_res;

	// Row store: two rows of cells, two read ports, one write port.
	cell_t           mem_q [2**AW];
	logic [AW-1:0]   addr_a, addr_b, addr_w;
	cell_t           ra_q, rb_q;

	item_t           it_q, it_s1, it_s2, it_s3, it_s4, it_s5;
	cell_t           left_q, mid_q;
	cell_t           mid_s2, mid_s3, mid_s4;
	logic [COL_W-1:0] xa_in, xa_it;

	logic signed [47:0] pxr_s2, pxl_s2, pyc_s2, pyu_s2;
	logic signed [41:0] gxc_s2, gyc_s2;
	logic signed [24:0] gx, gy;
	logic signed [49:0] sum, sum_r;
	logic signed [41:0] gxr, gyr;
	logic signed [25:0] gxt, gyt;
	logic signed [33:0] div_s3;
	logic signed [26:0] un_s3, vn_s3, un_s4, vn_s4;
	logic signed [50:0] mprod_s4, mprod_r;
	logic signed [34:0] mterm;
	logic signed [35:0] hn;
	result_t            up_res, last_res;

	assign xa_in = q_item.x[COL_W-1:0];
	assign xa_it = it_q.x[COL_W-1:0];
	assign n_res = 2'(q_item.flags.emit_up) + 2'(q_item.flags.emit_last);
	assign issue = (state_q == ST_IDLE) && q_valid &&
		(reserved_q <= RW'(RES_DEPTH - 2));
	assign q_pop = issue;

	// Read addresses: left and middle of the row above, then right and two rows up.
	always_comb begin
		if (state_q == ST_IDLE) begin
			addr_a = {~q_item.y[0], xa_in - COL_W'(1)};
			addr_b = {~q_item.y[0], xa_in};
		end else begin
			addr_a = {~it_q.y[0], xa_it + COL_W'(1)};
			addr_b = {it_q.y[0], xa_it};
		end
		addr_w = {it_q.y[0], xa_it};
	end

	// Memory with registered reads; a read of the written address returns old data.
	always_ff @(posedge clk) begin
		ra_q <= mem_q[addr_a];
		rb_q <= mem_q[addr_b];
		if (state_q == ST_READ) begin
			mem_q[addr_w] <= it_q.data;
		end
	end

	// Sequencer, stage valids and result credit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			reserved_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (issue) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			v_s1 <= (state_q == ST_READ);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && it_s4.flags.emit_up && it_s4.flags.emit_last;
			reserved_q <= reserved_q + (issue ? RW'(n_res) : '0) - RW'(res_pop);
		end
	end

	// Stage one operands.
	always_comb begin
		gx = 25'(ra_q.hc) - 25'(left_q.hc);
		gy = 25'(it_s1.data.hc) - 25'(rb_q.hc);
	end

	// Stage two: flux sum and height gradient rounding.
	always_comb begin
		sum   = 50'(pxr_s2) - 50'(pxl_s2) + 50'(pyc_s2) - 50'(pyu_s2);
		sum_r = sum + 50'sd32768;
		gxr   = gxc_s2 + 42'sd32768;
		gyr   = gyc_s2 + 42'sd32768;
		gxt   = gxr[41:16];
		gyt   = gyr[41:16];
	end

	// Stage four: mass term and result assembly.
	always_comb begin
		mprod_r = mprod_s4 + 51'sd32768;
		mterm   = mprod_r[50:16];
		hn      = 36'(mid_s4.hp) - 36'(mterm);

		up_res.x         = it_s4.x[7:0];
		up_res.y         = it_s4.y - 1'b1;
		up_res.run_last  = !it_s4.flags.emit_last;
		up_res.frame_end = 1'b0;
		if (it_s4.flags.on_edge) begin
			up_res.hn = mid_s4.hp;
			up_res.un = mid_s4.u;
			up_res.vn = mid_s4.v;
		end else begin
			up_res.hn = sat24(40'(hn));
			up_res.un = sat24(40'(un_s4));
			up_res.vn = sat24(40'(vn_s4));
		end

		last_res.x         = it_s5.x[7:0];
		last_res.y         = it_s5.y;
		last_res.hn        = it_s5.data.hp;
		last_res.un        = it_s5.data.u;
		last_res.vn        = it_s5.data.v;
		last_res.run_last  = 1'b1;
		last_res.frame_end = it_s5.flags.frame_end;
		if (!it_s4.flags.emit_up) begin
			last_res.x         = it_s4.x[7:0];
			last_res.y         = it_s4.y;
			last_res.hn        = it_s4.data.hp;
			last_res.un        = it_s4.data.u;
			last_res.vn        = it_s4.data.v;
			last_res.frame_end = it_s4.flags.frame_end;
		end
	end

	// Result issue: the row-above result first, the last-row result after it.
	always_comb begin
		res_push = v_s5 || (v_s4 && (it_s4.flags.emit_up || it_s4.flags.emit_last));
		if (v_s4 && it_s4.flags.emit_up) begin
			res_data = up_res;
		end else begin
			res_data = last_res;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (issue) begin
			it_q <= q_item;
		end
		if (state_q == ST_READ) begin
			left_q <= ra_q;
			mid_q  <= rb_q;
			it_s1  <= it_q;
		end
		pxr_s2 <= $signed(ra_q.u) * $signed({1'b0, ra_q.d});
		pxl_s2 <= $signed(left_q.u) * $signed({1'b0, left_q.d});
		pyc_s2 <= $signed(it_s1.data.v) * $signed({1'b0, it_s1.data.d});
		pyu_s2 <= $signed(rb_q.v) * $signed({1'b0, rb_q.d});
		gxc_s2 <= gx * $signed({1'b0, c1});
		gyc_s2 <= gy * $signed({1'b0, c1});
		it_s2  <= it_s1;
		mid_s2 <= mid_q;

		div_s3 <= sum_r[49:16];
		un_s3  <= 27'(mid_s2.u) - 27'(gxt);
		vn_s3  <= 27'(mid_s2.v) - 27'(gyt);
		it_s3  <= it_s2;
		mid_s3 <= mid_s2;

		mprod_s4 <= div_s3 * $signed({1'b0, c0});
		un_s4    <= un_s3;
		vn_s4    <= vn_s3;
		it_s4    <= it_s3;
		mid_s4   <= mid_s3;

		it_s5 <= it_s4;
	end

endmodule

// ===== design/shallow_water_stencil_step.sv =====
// Top level of the linearized shallow-water stencil step.
//
// Cells of a grid are pushed in raster order through push/full; each word
// carries both height levels, both velocities and the resting depth.
// Results are read through empty/pop: the finished cell of the row above
// (x, y-1) follows every cell of rows one and up, and cells of the last
// row come out once more on their own. run_last marks the final result of
// one input word; frame_end marks the last cell of the grid.
// Configuration goes through cfg_valid/cfg_ready with a register index and
// data; cfg_ready is always high. Write only while the block is idle.
// The back end takes no new cell while it reads the row store for the last
// one; the store's two read ports deliver the four neighbor words a cell
// needs in two reads. A result word passes the row-store reads and the
// stage registers; a last-row word of the same input follows next cycle.
// A four-word queue parts the front from the back and an eight-word result
// queue holds finished words; when the receiver stalls, the back stops
// issuing once the result queue could overflow, then full rises.
// Reset clears counters, queues and registers to their reset values; the
// row store keeps no reset and is filled by the first two rows.
`timescale 1ns / 1ps

module shallow_water_stencil_step
	import swss_pkg::*;
#(
	parameter int MAX_WIDTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [23:0] height_previous,
	input  logic signed [23:0] height_current,
	input  logic signed [23:0] velocity_x,
	input  logic signed [23:0] velocity_y,
	input  logic        [22:0] water_depth,
	output logic               empty,
	input  logic               pop,
	output logic        [7:0]  cell_x,
	output logic        [11:0] cell_y,
	output logic signed [23:0] height_new,
	output logic signed [23:0] velocity_x_new,
	output logic signed [23:0] velocity_y_new,
	output logic               run_last,
	output logic               frame_end,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data
);

	localparam int COL_W     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int RES_DEPTH = 8;

	logic [15:0] mass_q;
	logic [15:0] gravity_q;
	logic [8:0]  width_q;
	logic [12:0] height_q;
	geom_t       geom;
	cell_t       in_cell;

	logic        q_push, q_full, q_pop, q_empty;
	item_t       q_wdata, q_rdata;
	logic        res_push, res_full;
	result_t     res_wdata, res_rdata;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q    <= MASS_RESET;
			gravity_q <= GRAVITY_RESET;
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MASS:    mass_q    <= cfg_data;
				REG_GRAVITY: gravity_q <= cfg_data;
				REG_WIDTH:   width_q   <= cfg_data[8:0];
				REG_HEIGHT:  height_q  <= cfg_data[12:0];
				default:     mass_q    <= mass_q;
			endcase
		end
	end

	// Clamp the geometry to what the row store and counters support.
	always_comb begin
		if (13'(width_q) < MIN_DIM) begin
			geom.w = MIN_DIM;
		end else if (13'(width_q) > 13'(MAX_WIDTH)) begin
			geom.w = 13'(MAX_WIDTH);
		end else begin
			geom.w = 13'(width_q);
		end
		if (height_q < MIN_DIM) begin
			geom.h = MIN_DIM;
		end else if (height_q > MAX_ROWS) begin
			geom.h = MAX_ROWS;
		end else begin
			geom.h = height_q;
		end
	end

	// Input word.
	always_comb begin
		in_cell.hp = height_previous;
		in_cell.hc = height_current;
		in_cell.u  = velocity_x;
		in_cell.v  = velocity_y;
		in_cell.d  = water_depth;
	end
	assign full = q_full;

	swss_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cell_in (in_cell),
		.geom    (geom),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_wdata)
	);

	swss_fifo #(.WIDTH($bits(item_t)), .DEPTH(4)) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	swss_back #(.COL_W(COL_W), .RES_DEPTH(RES_DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!q_empty),
		.q_item   (q_rdata),
		.q_pop    (q_pop),
		.c0       (mass_q),
		.c1       (gravity_q),
		.res_push (res_push),
		.res_data (res_wdata),
		.res_pop  (pop && !empty)
	);

	swss_fifo #(.WIDTH($bits(result_t)), .DEPTH(RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	// Result ports.
	assign cell_x         = res_rdata.x;
	assign cell_y         = res_rdata.y;
	assign height_new     = res_rdata.hn;
	assign velocity_x_new = res_rdata.un;
	assign velocity_y_new = res_rdata.vn;
	assign run_last       = res_rdata.run_last;
	assign frame_end      = res_rdata.frame_end;

	// The credit count must keep the result queue from overflowing.
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result word pushed into a full queue");

	// The back end takes an item only when the queue holds one.
	a_item_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("item taken from an empty queue");

	// The last cell of a grid is always the final word of its input.
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> run_last)
		else $error("frame end without run end");

endmodule

// ===== dv/swss_checker.sv =====
// Checker for the shallow-water stencil block: predicts every result word and compares it.
`timescale 1ns / 1ps

module swss_checker
	import swss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic signed [23:0] height_previous,
	input  logic signed [23:0] height_current,
	input  logic signed [23:0] velocity_x,
	input  logic signed [23:0] velocity_y,
	input  logic        [22:0] water_depth,
	input  logic               empty,
	input  logic               pop,
	input  logic        [7:0]  cell_x,
	input  logic        [11:0] cell_y,
	input  logic signed [23:0] height_new,
	input  logic signed [23:0] velocity_x_new,
	input  logic signed [23:0] velocity_y_new,
	input  logic               run_last,
	input  logic               frame_end,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data,
	output int                 pending,
	output int                 errors
);

	localparam int ROW_LEN = 256;

	// Mirror of the block's registers and row stores.
	logic        [15:0] mass_k;
	logic        [15:0] gravity_k;
	logic        [8:0]  width_reg;
	logic        [12:0] height_reg;
	logic signed [23:0] hc_rows [2*ROW_LEN];
	logic signed [23:0] vy_rows [2*ROW_LEN];
	logic        [22:0] depth_rows [2*ROW_LEN];
	logic signed [23:0] u_row [ROW_LEN];
	logic signed [23:0] hp_row [ROW_LEN];
	logic signed [23:0] left_u;
	int                 col;
	int                 row;

	result_t expected_words [$];

	// Round a Q.16 product back to Q.16 (add one half, floor).
	function automatic longint round16(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	// Build one result word with saturation on the three value fields.
	function automatic result_t make_word(input int x, input int y, input longint h,
		input longint u, input longint v, input logic fe);
		result_t r;
		longint vals [3];
		logic signed [23:0] clipped [3];
		vals[0] = h;
		vals[1] = u;
		vals[2] = v;
		for (int i = 0; i < 3; i++) begin
			if (vals[i] > 64'sd8388607) begin
				clipped[i] = 24'sh7FFFFF;
			end else if (vals[i] < -64'sd8388608) begin
				clipped[i] = 24'sh800000;
			end else begin
				clipped[i] = vals[i][23:0];
			end
		end
		r.x = x[7:0];
		r.y = y[11:0];
		r.hn = clipped[0];
		r.un = clipped[1];
		r.vn = clipped[2];
		r.run_last = 1'b0;
		r.frame_end = fe;
		return r;
	endfunction

	// Advance the stencil by one accepted cell and queue the words it causes.
	task automatic predict_cell();
		int w, h, x, y, cur, oth, n;
		longint hp, hc, u, v, d, c0, c1, fx, fy, dv, gx, gy;
		longint ehp, eu, ev;
		result_t words [2];
		w = width_reg;
		h = height_reg;
		if (w < 3) w = 3;
		if (w > ROW_LEN) w = ROW_LEN;
		if (h < 3) h = 3;
		if (h > 4096) h = 4096;
		x = col % ROW_LEN;
		y = row;
		cur = (y & 1) * ROW_LEN + x;
		oth = ((y + 1) & 1) * ROW_LEN + x;
		hp = longint'(height_previous);
		hc = longint'(height_current);
		u = longint'(velocity_x);
		v = longint'(velocity_y);
		d = longint'(water_depth);
		c0 = longint'(mass_k);
		c1 = longint'(gravity_k);
		n = 0;
		// The cell of the row above is finished by this arrival.
		if (y >= 1) begin
			ehp = longint'(hp_row[x]);
			eu = longint'(u_row[x]);
			ev = longint'(vy_rows[oth]);
			if (x == 0 || x + 1 >= w || y == 1) begin
				words[0] = make_word(x, y - 1, ehp, eu, ev, 1'b0);
			end else begin
				fx = longint'(u_row[x+1]) * longint'(depth_rows[oth+1])
					- longint'(left_u) * longint'(depth_rows[oth-1]);
				fy = v * d - longint'(vy_rows[cur]) * longint'(depth_rows[cur]);
				dv = round16(fx + fy);
				gx = longint'(hc_rows[oth+1]) - longint'(hc_rows[oth-1]);
				gy = hc - longint'(hc_rows[cur]);
				words[0] = make_word(x, y - 1, ehp - round16(dv * c0),
					eu - round16(gx * c1), ev - round16(gy * c1), 1'b0);
			end
			n = 1;
		end
		// Update the row stores.
		left_u = u_row[x];
		hp_row[x] = height_previous;
		u_row[x] = velocity_x;
		hc_rows[cur] = height_current;
		vy_rows[cur] = velocity_y;
		depth_rows[cur] = water_depth;
		// Cells of the last row also go out on their own.
		if (y + 1 >= h) begin
			words[n] = make_word(x, y, hp, u, v, x + 1 >= w);
			n++;
		end
		if (n > 0) begin
			words[n-1].run_last = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			expected_words.push_back(words[i]);
		end
		if (x + 1 >= w) begin
			col = 0;
			row = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			col = x + 1;
		end
	endtask

	// Compare one popped word against the oldest expectation.
	task automatic check_word();
		result_t e;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected word x=%0d y=%0d", $time, cell_x, cell_y);
			errors++;
			return;
		end
		e = expected_words.pop_front();
		if (cell_x !== e.x) begin
			$display("%0t: cell_x expected %0d actual %0d", $time, e.x, cell_x);
			errors++;
		end
		if (cell_y !== e.y) begin
			$display("%0t: cell_y expected %0d actual %0d", $time, e.y, cell_y);
			errors++;
		end
		if (height_new !== e.hn) begin
			$display("%0t: height_new expected %0d actual %0d", $time, e.hn, height_new);
			errors++;
		end
		if (velocity_x_new !== e.un) begin
			$display("%0t: velocity_x_new expected %0d actual %0d", $time, e.un,
				velocity_x_new);
			errors++;
		end
		if (velocity_y_new !== e.vn) begin
			$display("%0t: velocity_y_new expected %0d actual %0d", $time, e.vn,
				velocity_y_new);
			errors++;
		end
		if (run_last !== e.run_last) begin
			$display("%0t: run_last expected %0d actual %0d", $time, e.run_last, run_last);
			errors++;
		end
		if (frame_end !== e.frame_end) begin
			$display("%0t: frame_end expected %0d actual %0d", $time, e.frame_end, frame_end);
			errors++;
		end
	endtask

	// Watch all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_k = MASS_RESET;
			gravity_k = GRAVITY_RESET;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col = 0;
			row = 0;
			left_u = '0;
			for (int i = 0; i < 2*ROW_LEN; i++) begin
				hc_rows[i] = '0;
				vy_rows[i] = '0;
				depth_rows[i] = '0;
			end
			for (int i = 0; i < ROW_LEN; i++) begin
				u_row[i] = '0;
				hp_row[i] = '0;
			end
			expected_words.delete();
		end else begin
			if (pop && !empty) begin
				check_word();
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MASS:    mass_k = cfg_data;
					REG_GRAVITY: gravity_k = cfg_data;
					REG_WIDTH:   width_reg = cfg_data[8:0];
					REG_HEIGHT:  height_reg = cfg_data[12:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				predict_cell();
			end
		end
		pending = expected_words.size();
	end

endmodule

// ===== dv/shallow_water_stencil_step_tb.sv =====
// Testbench top of the shallow-water stencil block: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module shallow_water_stencil_step_tb;
	import swss_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_CELLS = 160;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [23:0] height_previous;
	logic signed [23:0] height_current;
	logic signed [23:0] velocity_x;
	logic signed [23:0] velocity_y;
	logic        [22:0] water_depth;
	logic               empty;
	logic               pop;
	logic        [7:0]  cell_x;
	logic        [11:0] cell_y;
	logic signed [23:0] height_new;
	logic signed [23:0] velocity_x_new;
	logic signed [23:0] velocity_y_new;
	logic               run_last;
	logic               frame_end;
	logic               cfg_valid;
	logic               cfg_ready;
	logic        [1:0]  cfg_index;
	logic        [15:0] cfg_data;
	int                 pending;
	int                 errors;
	logic               calm;
	int                 stall_left;
	int                 quiet_cycles;

	shallow_water_stencil_step u_dut (.*);

	swss_checker u_checker (.*);

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: pop with random stall bursts, none once the run is calm.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 15);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Watchdog: ends the run when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("shallow_water_stencil_step_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// A 24-bit value biased toward the extremes and small magnitudes.
	function automatic logic [23:0] pick24();
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3, 4: return 24'($urandom);
			default: return 24'($urandom_range(0, 2**20) - 2**19);
		endcase
	endfunction

	// Push one cell word; an idle burst may come first.
	task automatic send_cell(input logic [23:0] hp, input logic [23:0] hc,
		input logic [23:0] u, input logic [23:0] v, input logic [22:0] d);
		logic was_full;
		if (!calm && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		push <= 1'b1;
		height_previous <= hp;
		height_current <= hc;
		velocity_x <= u;
		velocity_y <= v;
		water_depth <= d;
		do begin
			@(negedge clk);
			was_full = full;
			@(posedge clk);
		end while (was_full);
	endtask

	task automatic send_random(input int n);
		logic [23:0] d;
		for (int i = 0; i < n; i++) begin
			d = ($urandom_range(0, 5) == 0) ? 24'h7FFFFF : pick24();
			send_cell(pick24(), pick24(), pick24(), pick24(), d[22:0]);
		end
	endtask

	// Stop sending, wait for every expected word, then let the pipeline drain.
	task automatic settle();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
	endtask

	// One configuration write; cfg_valid stays up for a following write.
	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic configure(input logic [15:0] mass, input logic [15:0] grav,
		input logic [8:0] w, input logic [12:0] h);
		cfg_write(REG_MASS, mass);
		cfg_write(REG_GRAVITY, grav);
		cfg_write(REG_WIDTH, {7'd0, w});
		cfg_write(REG_HEIGHT, {3'd0, h});
		cfg_valid <= 1'b0;
	endtask

	task automatic change_height(input logic [12:0] h);
		cfg_write(REG_HEIGHT, {3'd0, h});
		cfg_valid <= 1'b0;
	endtask

	task automatic change_width(input logic [8:0] w);
		cfg_write(REG_WIDTH, {7'd0, w});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int sent, w, h;
		arst_n = 1'b0;
		push = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MASS;
		cfg_data = '0;
		height_previous = '0;
		height_current = '0;
		velocity_x = '0;
		velocity_y = '0;
		water_depth = '0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest grid with full-scale coefficients: all maxima, all minima, mixed.
		configure(16'hFFFF, 16'hFFFF, 9'd3, 13'd3);
		for (int i = 0; i < 9; i++) begin
			case (i % 3)
				0: send_cell(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF);
				1: send_cell(24'h800000, 24'h800000, 24'h800000, 24'h800000, 23'h0);
				default: send_cell(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 23'h7FFFFF);
			endcase
		end
		settle();

		// Zero coefficients; width and height below the minimum clamp to three.
		configure(16'd0, 16'd0, 9'd0, 13'd1);
		send_random(9);
		settle();

		// Height shrunk at the start of row two: that row becomes the last.
		configure(16'd40000, 16'd9000, 9'd6, 13'd6);
		send_random(12);
		settle();
		change_height(13'd2);
		send_random(6);
		settle();

		// Height shrunk below the current row: the row counts as last and wraps.
		configure(16'd5000, 16'd30000, 9'd4, 13'd8);
		send_random(16);
		settle();
		change_height(13'd3);
		send_random(4);
		settle();

		// Width shrunk at the start of a row.
		configure(16'd1311, 16'd6423, 9'd8, 13'd5);
		send_random(16);
		settle();
		change_width(9'd5);
		send_random(15);
		settle();

		// Widest grid (oversized width clamps to the store length).
		configure(16'd777, 16'd4321, 9'd511, 13'd0);
		send_random(256 * 3);
		settle();

		// Tall grid (oversized height clamps), narrowest width; after a few rows
		// the height shrinks below the current row, which then ends the frame.
		configure(16'd2000, 16'd100, 9'd2, 13'd8191);
		send_random(3 * 5);
		settle();
		change_height(13'd3);
		send_random(3);
		settle();

		// Random frames of mostly small sizes with random coefficients.
		sent = 0;
		while (sent < RANDOM_CELLS) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 30) : $urandom_range(3, 10);
			h = $urandom_range(3, 8);
			configure(($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom),
				($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom), w[8:0], h[12:0]);
			send_random(w * h);
			sent += w * h;
			settle();
		end

		// Last frame with no idling on either side.
		calm = 1'b1;
		configure(16'd3000, 16'd12000, 9'd10, 13'd8);
		send_random(10 * 8);
		settle();

		if (errors == 0) begin
			$display("shallow_water_stencil_step_tb OK");
		end else begin
			$display("shallow_water_stencil_step_tb NOT OK");
		end
		$finish;
	end

endmodule
